>>> rtl/d2cp_pkg.sv
// shared types, widths and helper functions for the disparity to colored point block
// no dependencies; imported by every module of the block
package d2cp_pkg;

   // field widths
   localparam int REG_W      = 40;
   localparam int REG_COUNT  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int PIXEL_W    = 12;
   localparam int DISP_W     = 16;
   localparam int COLOR_W    = 8;
   localparam int LANES      = 3;

   // only the low COORD_BITS bits of row and column take part
   localparam int COORD_BITS = 12;
   localparam int COORD_W    = (COORD_BITS < PIXEL_W) ? COORD_BITS : PIXEL_W;

   // arithmetic widths
   localparam int PROD_W     = REG_W + COORD_W + 1;
   localparam int NUM_W      = PROD_W + 1;
   localparam int W_W        = REG_W + DISP_W + 1;
   localparam int DEN_W      = REG_W + DISP_W;
   localparam int FRAC_SHIFT = 20;
   localparam int QUOT_W     = 32;
   localparam int DVD_W      = NUM_W + FRAC_SHIFT;
   localparam int HI_W       = DVD_W - QUOT_W;
   localparam int CMP_W      = (HI_W > DEN_W) ? HI_W : DEN_W;
   localparam int DIV_STEPS  = QUOT_W;

   localparam logic [QUOT_W-1:0] COORD_MAX = {1'b0, {(QUOT_W-1){1'b1}}};
   localparam logic [QUOT_W-1:0] COORD_MIN = {1'b1, {(QUOT_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_SCALE    = 3'd0,
      CSR_X_OFFSET   = 3'd1,
      CSR_Y_SCALE    = 3'd2,
      CSR_Y_OFFSET   = 3'd3,
      CSR_DEPTH_TERM = 3'd4,
      CSR_W_SCALE    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_row;
      logic [PIXEL_W-1:0] pixel_col;
      logic [DISP_W-1:0]  disparity;
      logic [COLOR_W-1:0] blue_in;
      logic [COLOR_W-1:0] green_in;
      logic [COLOR_W-1:0] red_in;
   } req_type;

   typedef struct packed {
      logic               point_valid;
      logic signed [QUOT_W-1:0] x_pos;
      logic signed [QUOT_W-1:0] y_pos;
      logic signed [QUOT_W-1:0] z_pos;
      logic [COLOR_W-1:0] blue_out;
      logic [COLOR_W-1:0] green_out;
      logic [COLOR_W-1:0] red_out;
   } rsp_type;

   typedef struct packed {
      logic signed [REG_W-1:0] q_x_scale;
      logic signed [REG_W-1:0] q_x_offset;
      logic signed [REG_W-1:0] q_y_scale;
      logic signed [REG_W-1:0] q_y_offset;
      logic signed [REG_W-1:0] q_depth_term;
      logic signed [REG_W-1:0] q_w_scale;
   } csr_regs_type;

   typedef struct packed {
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } color_type;

   // one coordinate in flight through the divider
   // bits holds the dividend bits still to shift in, and collects quotient bits
   typedef struct packed {
      logic [DEN_W-1:0]  rem;
      logic [QUOT_W-1:0] bits;
      logic              ovf;
      logic              neg;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [LANES-1:0] lane;
      logic [DEN_W-1:0]         den;
      logic                     point_ok;
      color_type                color;
   } div_item_type;

   // one restoring division step
   function automatic div_lane_type div_step(div_lane_type a, logic [DEN_W-1:0] den);
      logic [DEN_W:0] part;
      logic [DEN_W:0] diff;
      logic           ge;
      div_lane_type   r;
      part   = {a.rem, a.bits[QUOT_W-1]};
      ge     = (part >= {1'b0, den});
      diff   = part - {1'b0, den};
      r      = a;
      r.rem  = ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
      r.bits = {a.bits[QUOT_W-2:0], ge};
      return r;
   endfunction

   function automatic div_item_type div_item_step(div_item_type a);
      div_item_type r;
      r = a;
      for (int l = 0; l < LANES; l++) begin
         r.lane[l] = div_step(a.lane[l], a.den);
      end
      return r;
   endfunction

endpackage

>>> rtl/d2cp_csr.sv
// reprojection matrix registers, written through a plain write port
// depends on d2cp_pkg
module d2cp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [d2cp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [d2cp_pkg::REG_W-1:0]     csr_data,
   output d2cp_pkg::csr_regs_type         regs
);
   import d2cp_pkg::*;

   csr_regs_type regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_X_SCALE:    regs_ff.q_x_scale    <= signed'(csr_data);
            CSR_X_OFFSET:   regs_ff.q_x_offset   <= signed'(csr_data);
            CSR_Y_SCALE:    regs_ff.q_y_scale    <= signed'(csr_data);
            CSR_Y_OFFSET:   regs_ff.q_y_offset   <= signed'(csr_data);
            CSR_DEPTH_TERM: regs_ff.q_depth_term <= signed'(csr_data);
            CSR_W_SCALE:    regs_ff.q_w_scale    <= signed'(csr_data);
            default: begin
               // index beyond the register list is dropped
            end
         endcase
      end
   end

   assign regs = regs_ff;

endmodule

>>> rtl/d2cp_front.sv
// front end: products, numerators, magnitudes and divider setup in four stages
// depends on d2cp_pkg
module d2cp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  d2cp_pkg::csr_regs_type regs,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  d2cp_pkg::req_type      in_item,
   output logic                   out_valid,
   input  logic                   out_stall,
   output d2cp_pkg::div_item_type out_item
);
   import d2cp_pkg::*;

   localparam int STAGES = 4;

   typedef struct packed {
      logic signed [PROD_W-1:0] px;
      logic signed [PROD_W-1:0] py;
      logic signed [W_W-1:0]    pw;
      color_type                color;
   } mul_stage_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] nx;
      logic signed [NUM_W-1:0] ny;
      logic signed [NUM_W-1:0] nz;
      logic signed [W_W-1:0]   pw;
      color_type               color;
   } sum_stage_type;

   typedef struct packed {
      logic [LANES-1:0][NUM_W-1:0] mag;
      logic [LANES-1:0]            neg;
      logic [DEN_W-1:0]            den;
      logic                        point_ok;
      color_type                   color;
   } abs_stage_type;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] rdy;

   mul_stage_type s1_ff, s1_in;
   sum_stage_type s2_ff, s2_in;
   abs_stage_type s3_ff, s3_in;
   div_item_type  s4_ff, s4_in;

   logic signed [COORD_W:0] col_s;
   logic signed [COORD_W:0] row_s;
   logic signed [DISP_W:0]  disp_s;

   // a stage moves when it is empty or its successor moves
   always_comb begin
      rdy[STAGES-1] = !v_ff[STAGES-1] || !out_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign in_stall  = !rdy[0];
   assign out_valid = v_ff[STAGES-1];
   assign out_item  = s4_ff;

   // stage 1: the three products
   assign col_s  = {1'b0, in_item.pixel_col[COORD_W-1:0]};
   assign row_s  = {1'b0, in_item.pixel_row[COORD_W-1:0]};
   assign disp_s = {1'b0, in_item.disparity};

   always_comb begin
      s1_in.px          = PROD_W'(regs.q_x_scale) * PROD_W'(col_s);
      s1_in.py          = PROD_W'(regs.q_y_scale) * PROD_W'(row_s);
      s1_in.pw          = W_W'(regs.q_w_scale) * W_W'(disp_s);
      s1_in.color.blue  = in_item.blue_in;
      s1_in.color.green = in_item.green_in;
      s1_in.color.red   = in_item.red_in;
   end

   // stage 2: add offsets
   always_comb begin
      s2_in.nx    = NUM_W'(s1_ff.px) + NUM_W'(regs.q_x_offset);
      s2_in.ny    = NUM_W'(s1_ff.py) + NUM_W'(regs.q_y_offset);
      s2_in.nz    = NUM_W'(regs.q_depth_term);
      s2_in.pw    = s1_ff.pw;
      s2_in.color = s1_ff.color;
   end

   // stage 3: sign and magnitude of numerators and w
   always_comb begin : abs_comb
      logic [LANES-1:0][NUM_W-1:0] num;
      logic                        w_neg;
      logic [W_W-1:0]              w_abs;
      num[0] = s2_ff.nx;
      num[1] = s2_ff.ny;
      num[2] = s2_ff.nz;
      w_neg  = s2_ff.pw[W_W-1];
      w_abs  = w_neg ? W_W'(~s2_ff.pw + 1'b1) : W_W'(s2_ff.pw);
      for (int l = 0; l < LANES; l++) begin
         s3_in.mag[l] = num[l][NUM_W-1] ? NUM_W'(~num[l] + 1'b1) : num[l];
         s3_in.neg[l] = num[l][NUM_W-1] ^ w_neg;
      end
      s3_in.den      = w_abs[DEN_W-1:0];
      s3_in.point_ok = (s2_ff.pw != '0);
      s3_in.color    = s2_ff.color;
   end

   // stage 4: align dividend, catch quotients that cannot fit 32 bits
   always_comb begin : init_comb
      logic [DVD_W-1:0] dvd;
      logic [HI_W-1:0]  hi;
      dvd = '0;
      hi  = '0;
      for (int l = 0; l < LANES; l++) begin
         dvd                 = {s3_ff.mag[l], {FRAC_SHIFT{1'b0}}};
         hi                  = dvd[DVD_W-1:QUOT_W];
         s4_in.lane[l].ovf   = (CMP_W'(hi) >= CMP_W'(s3_ff.den));
         s4_in.lane[l].rem   = DEN_W'(hi);
         s4_in.lane[l].bits  = dvd[QUOT_W-1:0];
         s4_in.lane[l].neg   = s3_ff.neg[l];
      end
      s4_in.den      = s3_ff.den;
      s4_in.point_ok = s3_ff.point_ok;
      s4_in.color    = s3_ff.color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) s1_ff <= s1_in;
      if (rdy[1]) s2_ff <= s2_in;
      if (rdy[2]) s3_ff <= s3_in;
      if (rdy[3]) s4_ff <= s4_in;
   end

endmodule

>>> rtl/d2cp_divider.sv
// pipelined restoring divider: one quotient bit per stage for all three coordinates
// depends on d2cp_pkg
module d2cp_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  d2cp_pkg::div_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_stall,
   output d2cp_pkg::div_item_type out_item
);
   import d2cp_pkg::*;

   logic [DIV_STEPS-1:0] v_ff;
   logic [DIV_STEPS-1:0] rdy;
   div_item_type         stg_ff [DIV_STEPS];
   div_item_type         stg_in [DIV_STEPS];

   always_comb begin
      rdy[DIV_STEPS-1] = !v_ff[DIV_STEPS-1] || !out_stall;
      for (int k = DIV_STEPS - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      stg_in[0] = div_item_step(in_item);
      for (int k = 1; k < DIV_STEPS; k++) begin
         stg_in[k] = div_item_step(stg_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < DIV_STEPS; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (rdy[k]) stg_ff[k] <= stg_in[k];
      end
   end

   assign in_stall  = !rdy[0];
   assign out_valid = v_ff[DIV_STEPS-1];
   assign out_item  = stg_ff[DIV_STEPS-1];

endmodule

>>> rtl/d2cp_output.sv
// output register: sign, saturation and the invalid-point case
// depends on d2cp_pkg
module d2cp_output (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  d2cp_pkg::div_item_type in_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output d2cp_pkg::rsp_type      rsp_item
);
   import d2cp_pkg::*;

   logic    v_ff;
   logic    rdy;
   rsp_type rsp_ff, rsp_in;

   function automatic logic [QUOT_W-1:0] sat_coord(div_lane_type a);
      logic [QUOT_W-1:0] r;
      if (a.ovf) begin
         r = a.neg ? COORD_MIN : COORD_MAX;
      end else if (a.neg) begin
         r = (a.bits > COORD_MIN) ? COORD_MIN : QUOT_W'(~a.bits + 1'b1);
      end else begin
         r = a.bits[QUOT_W-1] ? COORD_MAX : a.bits;
      end
      return r;
   endfunction

   assign rdy = !v_ff || !rsp_stall;

   always_comb begin
      rsp_in.point_valid = in_item.point_ok;
      rsp_in.x_pos       = in_item.point_ok ? signed'(sat_coord(in_item.lane[0])) : '0;
      rsp_in.y_pos       = in_item.point_ok ? signed'(sat_coord(in_item.lane[1])) : '0;
      rsp_in.z_pos       = in_item.point_ok ? signed'(sat_coord(in_item.lane[2])) : '0;
      rsp_in.blue_out    = in_item.color.blue;
      rsp_in.green_out   = in_item.color.green;
      rsp_in.red_out     = in_item.color.red;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (rdy) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy) rsp_ff <= rsp_in;
   end

   assign in_stall  = !rdy;
   assign rsp_valid = v_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> rtl/disparity_to_colored_point.sv
// Reprojects one disparity pixel per item to a colored 3D point: w = q_w_scale*disparity,
// x = (q_x_scale*col + q_x_offset)/w, y = (q_y_scale*row + q_y_offset)/w,
// z = q_depth_term/w, all signed Q12.20 with saturation; zero w gives an invalid point with
// zero coordinates, and the color passes through. The block takes one item every cycle
// while the result side does not stall. An item passes 37 register stages: four front
// stages (multiply, offset add, magnitude, dividend setup), then 32 divider stages that
// each resolve one quotient bit for all three coordinates, then the output register.
// Every stage has its own valid bit, so bubbles close up while the result side stalls.
// Registers are to be written through csr_write/csr_index/csr_data only while no item is in
// flight; the block itself does not enforce this.
module disparity_to_colored_point (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [d2cp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [d2cp_pkg::REG_W-1:0]     csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  d2cp_pkg::req_type              req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output d2cp_pkg::rsp_type              rsp_item
);
   import d2cp_pkg::*;

   csr_regs_type regs;
   logic         front_valid, front_stall;
   div_item_type front_item;
   logic         div_valid, div_stall;
   div_item_type div_item;

   d2cp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .regs      (regs)
   );

   d2cp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .regs      (regs),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_stall (front_stall),
      .out_item  (front_item)
   );

   d2cp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_item   (front_item),
      .out_valid (div_valid),
      .out_stall (div_stall),
      .out_item  (div_item)
   );

   d2cp_output u_output (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_stall  (div_stall),
      .in_item   (div_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
